/* rtl/core/bmpd_pkg.sv */
// bmpd_pkg: shared types and constants for the 24-bit BMP stream decoder.
// Used by bmpd_parser, bmpd_outq and bmp24_stream_decoder. No dependencies.
package bmpd_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COORD_W    = 12;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
  localparam logic [15:0] BITS_PER_PIX  = 16'd24;
  localparam logic [31:0] MIN_DATA_OFS  = 32'd54;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_SIGNATURE = 3'd0,
    ERR_HDR_SIZE  = 3'd1,
    ERR_FORMAT    = 3'd2,
    ERR_DIMENSION = 3'd3,
    ERR_DATA_OFS  = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_code_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   storage_row;
    err_code_t            error_code;
  } result_t;

  // Up to two results per byte: slot 1 is only used with slot 0.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t item0;
    result_t item1;
  } res_pair_t;

endpackage

/* rtl/core/bmpd_parser.sv */
// bmpd_parser: header parse, checks and pixel assembly, one byte per cycle while byte_fire is high.
// Depends on bmpd_pkg.
module bmpd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_fire,
  input  logic [7:0]          file_byte,
  input  logic                first_byte,
  input  logic                stream_end,
  output bmpd_pkg::res_pair_t res
);
  import bmpd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_PAD
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic [31:0]        hshift_r, hshift_nxt;
  logic [31:0]        pix_ofs_r, pix_ofs_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic               top_down_r, top_down_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [1:0]         bip_r, bip_nxt;
  logic [1:0]         pad_r, pad_nxt;
  logic [15:0]        held_r, held_nxt;

  logic               pix_emit, done_emit, err_emit;
  err_code_t          err_code;
  logic [31:0]        mag;
  logic [DIM_W-1:0]   row_ext;
  logic [DIM_W-1:0]   flip_row;
  logic               end_row;
  result_t            pix_item, done_item, err_item;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    hshift_nxt   = hshift_r;
    pix_ofs_nxt  = pix_ofs_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    top_down_nxt = top_down_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    bip_nxt      = bip_r;
    pad_nxt      = pad_r;
    held_nxt     = held_r;
    pix_emit     = 1'b0;
    done_emit    = 1'b0;
    err_emit     = 1'b0;
    err_code     = ERR_SIGNATURE;
    mag          = 32'd0;
    end_row      = 1'b0;
    row_ext      = {1'b0, row_r};
    flip_row     = height_r - DIM_W'(1) - row_ext;

    if (byte_fire) begin
      if (stream_end) begin
        if (phase_r != PH_IDLE) begin
          err_emit  = 1'b1;
          err_code  = ERR_TRUNCATED;
          phase_nxt = PH_IDLE;
        end
      end else begin
        if (first_byte) begin
          pos_nxt      = 32'd0;
          hshift_nxt   = 32'd0;
          pix_ofs_nxt  = 32'd0;
          width_nxt    = '0;
          height_nxt   = '0;
          top_down_nxt = 1'b0;
          col_nxt      = '0;
          row_nxt      = '0;
          bip_nxt      = 2'd0;
          pad_nxt      = 2'd0;
          held_nxt     = 16'd0;
          phase_nxt    = PH_HEADER;
        end
        row_ext  = {1'b0, row_nxt};
        flip_row = height_nxt - DIM_W'(1) - row_ext;

        unique case (phase_nxt)
          PH_HEADER: begin
            hshift_nxt = {file_byte, hshift_nxt[31:8]};
            case (pos_nxt)
              32'd1: begin
                if (hshift_nxt[31:16] != BMP_SIGNATURE) begin
                  err_emit = 1'b1;
                  err_code = ERR_SIGNATURE;
                end
              end
              32'd13: pix_ofs_nxt = hshift_nxt;
              32'd17: begin
                if (hshift_nxt != INFO_HDR_SIZE) begin
                  err_emit = 1'b1;
                  err_code = ERR_HDR_SIZE;
                end
              end
              32'd21: begin
                if (hshift_nxt[31] || hshift_nxt == 32'd0 ||
                    hshift_nxt > 32'(MAX_WIDTH))
                  width_nxt = '0;
                else
                  width_nxt = hshift_nxt[DIM_W-1:0];
              end
              32'd25: begin
                mag          = hshift_nxt[31] ? (~hshift_nxt + 32'd1) : hshift_nxt;
                top_down_nxt = hshift_nxt[31];
                if (mag == 32'd0 || mag > 32'(MAX_HEIGHT))
                  height_nxt = '0;
                else
                  height_nxt = mag[DIM_W-1:0];
              end
              32'd29: begin
                if (hshift_nxt[31:16] != BITS_PER_PIX) begin
                  err_emit = 1'b1;
                  err_code = ERR_FORMAT;
                end
              end
              32'd33: begin
                if (hshift_nxt != 32'd0) begin
                  err_emit = 1'b1;
                  err_code = ERR_FORMAT;
                end else if (width_nxt == '0 || height_nxt == '0) begin
                  err_emit = 1'b1;
                  err_code = ERR_DIMENSION;
                end else if (pix_ofs_nxt < MIN_DATA_OFS) begin
                  err_emit = 1'b1;
                  err_code = ERR_DATA_OFS;
                end
              end
              32'd53: phase_nxt = (pix_ofs_nxt == MIN_DATA_OFS) ? PH_PIXELS : PH_SKIP;
              default: ;
            endcase
            if (err_emit)
              phase_nxt = PH_IDLE;
          end
          PH_SKIP: begin
            if (pos_nxt + 32'd1 == pix_ofs_nxt)
              phase_nxt = PH_PIXELS;
          end
          PH_PIXELS: begin
            case (bip_nxt)
              2'd0: begin
                held_nxt = {8'd0, file_byte};
                bip_nxt  = 2'd1;
              end
              2'd1: begin
                held_nxt[15:8] = file_byte;
                bip_nxt        = 2'd2;
              end
              default: begin
                pix_emit = 1'b1;
                bip_nxt  = 2'd0;
                if ({1'b0, col_nxt} + DIM_W'(1) >= width_nxt) begin
                  col_nxt = '0;
                  pad_nxt = width_nxt[1:0];
                  if (width_nxt[1:0] != 2'd0)
                    phase_nxt = PH_PAD;
                  else
                    end_row = 1'b1;
                end else begin
                  col_nxt = col_nxt + COORD_W'(1);
                end
              end
            endcase
          end
          PH_PAD: begin
            pad_nxt = pad_nxt - 2'd1;
            if (pad_nxt == 2'd0)
              end_row = 1'b1;
          end
          default: ;
        endcase

        if (end_row) begin
          row_nxt = row_nxt + COORD_W'(1);
          if (row_ext + DIM_W'(1) >= height_nxt) begin
            done_emit = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_PIXELS;
          end
        end

        if (phase_r != PH_IDLE || first_byte)
          pos_nxt = pos_nxt + 32'd1;
      end
    end
  end

  always_comb begin
    pix_item             = '0;
    pix_item.kind        = KIND_PIXEL;
    pix_item.red         = file_byte;
    pix_item.green       = held_nxt[15:8];
    pix_item.blue        = held_nxt[7:0];
    pix_item.column      = first_byte ? '0 : col_r;
    pix_item.storage_row = top_down_r ? row_r : flip_row[COORD_W-1:0];
    pix_item.error_code  = ERR_SIGNATURE;

    done_item            = '0;
    done_item.kind       = KIND_DONE;
    done_item.error_code = ERR_SIGNATURE;

    err_item             = '0;
    err_item.kind        = KIND_ERROR;
    err_item.error_code  = err_code;

    res.push0 = pix_emit | done_emit | err_emit;
    res.push1 = pix_emit & done_emit;
    res.item0 = pix_emit ? pix_item : (done_emit ? done_item : err_item);
    res.item1 = done_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pos_r      <= 32'd0;
      hshift_r   <= 32'd0;
      pix_ofs_r  <= 32'd0;
      width_r    <= '0;
      height_r   <= '0;
      top_down_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      bip_r      <= 2'd0;
      pad_r      <= 2'd0;
      held_r     <= 16'd0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      hshift_r   <= hshift_nxt;
      pix_ofs_r  <= pix_ofs_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      top_down_r <= top_down_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      bip_r      <= bip_nxt;
      pad_r      <= pad_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

/* rtl/core/bmpd_outq.sv */
// bmpd_outq: four-entry result queue, takes up to two items per cycle.
// Depends on bmpd_pkg.
module bmpd_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  bmpd_pkg::res_pair_t res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output bmpd_pkg::result_t   out_item
);
  import bmpd_pkg::*;

  result_t    mem_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign room      = cnt_r <= 3'd2;
  assign out_valid = cnt_r != 3'd0;
  assign out_item  = mem_r[rp_r];
  assign pop       = out_valid & out_ready;

  always_comb begin
    wp_nxt  = wp_r + {1'b0, res.push0} + {1'b0, res.push1};
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {2'b0, res.push0} + {2'b0, res.push1} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (res.push0)
      mem_r[wp_r] <= res.item0;
    if (res.push1)
      mem_r[wp_r + 2'd1] <= res.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/bmp24_stream_decoder.sv */
// Decoder for 24-bit uncompressed BMP files arriving one byte per item.
// Takes one byte every clock while the result queue has room for two items: the
// parser updates its state in the cycle a byte is accepted and writes its results
// into a four-entry queue, so the rate is set by the output side draining the
// queue. A pixel and the done item can come from the same byte. Results are registered
// in the queue before they appear on the output.
// Depends on bmpd_pkg, bmpd_parser and bmpd_outq.
module bmp24_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // file_byte
  input  logic [1:0]  in_tuser,   // first_byte, stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // red, green, blue, column, storage_row, error_code
  output logic [1:0]  out_tuser   // kind
);
  import bmpd_pkg::*;

  res_pair_t res;
  result_t   item;
  logic      room;
  logic      byte_fire;

  assign in_tready = room;
  assign byte_fire = in_tvalid & room;

  bmpd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (byte_fire),
    .file_byte  (in_tdata),
    .first_byte (in_tuser[0]),
    .stream_end (in_tuser[1]),
    .res        (res)
  );

  bmpd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (item)
  );

  assign out_tuser = item.kind;
  assign out_tdata = {5'd0, item.error_code, item.storage_row, item.column,
                      item.blue, item.green, item.red};

endmodule

/* sim/bmp24_stream_decoder_tb.sv */
`timescale 1ns / 100ps
// Testbench for bmp24_stream_decoder: drives BMP byte streams, predicts pixel, done and error
// items with its own decoder and checks every result. Depends on bmpd_pkg and the RTL only.
module bmp24_stream_decoder_tb;
  import bmpd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam err_code_t   NO_ERROR     = ERR_SIGNATURE;

  class bmp_scoreboard;
    typedef enum logic [2:0] {PH_IDLE, PH_HEADER, PH_SKIP, PH_PIXELS, PH_PAD} phase_t;

    result_t     expected_q[$];
    phase_t      phase;
    logic [31:0] pos, shift_reg, data_ofs, width, height, col_cnt, row_cnt;
    logic [1:0]  pix_byte, pad_left;
    logic [15:0] held_bg;
    bit          top_down;
    int unsigned live_items, files, pixels, dones, errors, mismatches;

    function new();
      restart();
    endfunction

    function void restart();
      pos = '0;
      shift_reg = '0;
      data_ofs = '0;
      width = '0;
      height = '0;
      col_cnt = '0;
      row_cnt = '0;
      pix_byte = '0;
      pad_left = '0;
      held_bg = '0;
      top_down = 1'b0;
      phase = PH_IDLE;
    endfunction

    function void push(kind_t kind, logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                       logic [31:0] col, logic [31:0] row, err_code_t code);
      result_t r;
      r.kind        = kind;
      r.red         = red;
      r.green       = green;
      r.blue        = blue;
      r.column      = col[COORD_W-1:0];
      r.storage_row = row[COORD_W-1:0];
      r.error_code  = code;
      expected_q.push_back(r);
    endfunction

    function void abort_with(err_code_t code);
      push(KIND_ERROR, '0, '0, '0, '0, '0, code);
      phase = PH_IDLE;
    endfunction

    function void finish_row();
      row_cnt++;
      if (row_cnt >= height) begin
        push(KIND_DONE, '0, '0, '0, '0, '0, NO_ERROR);
        phase = PH_IDLE;
      end else begin
        phase = PH_PIXELS;
      end
    endfunction

    function void header_byte(logic [7:0] b);
      logic [31:0] mag;
      shift_reg = {b, shift_reg[31:8]};
      case (pos)
        32'd1: if (shift_reg[31:16] != BMP_SIGNATURE) abort_with(ERR_SIGNATURE);
        32'd13: data_ofs = shift_reg;
        32'd17: if (shift_reg != INFO_HDR_SIZE) abort_with(ERR_HDR_SIZE);
        32'd21: begin
          if (shift_reg[31] || shift_reg == 0 || shift_reg > MAX_WIDTH) width = '0;
          else width = shift_reg;
        end
        32'd25: begin
          top_down = shift_reg[31];
          mag = shift_reg[31] ? -shift_reg : shift_reg;
          height = (mag == 0 || mag > MAX_HEIGHT) ? '0 : mag;
        end
        32'd29: if (shift_reg[31:16] != BITS_PER_PIX) abort_with(ERR_FORMAT);
        32'd33: begin
          if (shift_reg != 0) abort_with(ERR_FORMAT);
          else if (width == 0 || height == 0) abort_with(ERR_DIMENSION);
          else if (data_ofs < MIN_DATA_OFS) abort_with(ERR_DATA_OFS);
        end
        32'd53: phase = (data_ofs == MIN_DATA_OFS) ? PH_PIXELS : PH_SKIP;
        default: ;
      endcase
    endfunction

    function void pixel_byte(logic [7:0] b);
      logic [31:0] row;
      if (pix_byte == 2'd0) begin
        held_bg = {8'h00, b};
        pix_byte = 2'd1;
      end else if (pix_byte == 2'd1) begin
        held_bg[15:8] = b;
        pix_byte = 2'd2;
      end else begin
        row = top_down ? row_cnt : height - 1 - row_cnt;
        push(KIND_PIXEL, b, held_bg[15:8], held_bg[7:0], col_cnt, row, NO_ERROR);
        pixels++;
        pix_byte = 2'd0;
        col_cnt++;
        if (col_cnt >= width) begin
          col_cnt = '0;
          pad_left = width[1:0];
          if (pad_left != 0) phase = PH_PAD;
          else finish_row();
        end
      end
    endfunction

    function void note_input(logic [7:0] b, bit first, bit endf);
      if (endf) begin
        if (phase != PH_IDLE) begin
          live_items++;
          abort_with(ERR_TRUNCATED);
        end
        return;
      end
      if (first) begin
        restart();
        phase = PH_HEADER;
        files++;
      end
      if (phase == PH_IDLE) return;
      live_items++;
      case (phase)
        PH_HEADER: header_byte(b);
        PH_SKIP: if (pos + 32'd1 == data_ofs) phase = PH_PIXELS;
        PH_PIXELS: pixel_byte(b);
        PH_PAD: begin
          pad_left = pad_left - 2'd1;
          if (pad_left == 0) finish_row();
        end
        default: ;
      endcase
      pos++;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task compare(string field, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d, expected %0d", field, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item, kind %0d data %h", got.kind, got));
        return;
      end
      want = expected_q.pop_front();
      if (want.kind == KIND_DONE) dones++;
      if (want.kind == KIND_ERROR) errors++;
      compare("kind", got.kind, want.kind);
      compare("red", got.red, want.red);
      compare("green", got.green, want.green);
      compare("blue", got.blue, want.blue);
      compare("column", got.column, want.column);
      compare("storage_row", got.storage_row, want.storage_row);
      compare("error_code", got.error_code, want.error_code);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  bmp_scoreboard sb = new();
  int unsigned   stall_cycles;
  int unsigned   bytes_sent;
  bit            in_burst;

  bmp24_stream_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int unsigned image_len(int unsigned w, int h, int unsigned ofs);
    int unsigned rows;
    rows = (h < 0) ? -h : h;
    return ofs + rows * (3 * w + (w % 4));
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit first, input bit endf);
    int unsigned gap;
    gap = in_burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= {endf, first};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the first len bytes of a file with the given header fields, random elsewhere.
  task automatic send_bmp(input logic [15:0] sig, input logic [31:0] ofs, input logic [31:0] hsz,
                          input logic [31:0] w, input logic [31:0] h, input logic [15:0] bpp,
                          input logic [31:0] comp, input int unsigned len, input bit end_after);
    logic [7:0] hdr [54];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    {hdr[1], hdr[0]} = sig;
    {hdr[13], hdr[12], hdr[11], hdr[10]} = ofs;
    {hdr[17], hdr[16], hdr[15], hdr[14]} = hsz;
    {hdr[21], hdr[20], hdr[19], hdr[18]} = w;
    {hdr[25], hdr[24], hdr[23], hdr[22]} = h;
    {hdr[29], hdr[28]} = bpp;
    {hdr[33], hdr[32], hdr[31], hdr[30]} = comp;
    for (int i = 0; i < len; i++) send_byte((i < 54) ? hdr[i] : 8'($urandom), i == 0, 1'b0);
    if (end_after) send_byte(8'($urandom), $urandom_range(0, 1) == 1, 1'b1);
  endtask

  task automatic send_valid_bmp(input int unsigned w, input int h, input int unsigned ofs,
                                input bit end_after);
    send_bmp(BMP_SIGNATURE, ofs, INFO_HDR_SIZE, w, h, BITS_PER_PIX, '0,
             image_len(w, h, ofs), end_after);
  endtask

  always @(posedge clk) begin : monitor
    result_t seen;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser[0], in_tuser[1]);
      if (out_tvalid && out_tready) begin
        seen.kind        = kind_t'(out_tuser);
        seen.red         = out_tdata[7:0];
        seen.green       = out_tdata[15:8];
        seen.blue        = out_tdata[23:16];
        seen.column      = out_tdata[35:24];
        seen.storage_row = out_tdata[47:36];
        seen.error_code  = err_code_t'(out_tdata[50:48]);
        sb.check_result(seen);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : sink
    int unsigned n;
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      n = pick_gap();
      if (n != 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned rand_start, w, ofs, full, ov;
    int          h;
    logic [31:0] wv, hv, hsz, comp;
    logic [15:0] sig, bpp;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    in_burst   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // well-formed files, stray bytes and an end while idle
    send_valid_bmp(1, 1, 54, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0, 1'b0);
    send_byte(8'($urandom), 1'b0, 1'b1);
    send_valid_bmp(4, 2, 54, 1'b0);
    send_valid_bmp(3, -3, 60, 1'b1);
    send_valid_bmp(5, 2, 55, 1'b0);

    // each header check, and the order of the checks after the compression field
    send_bmp(16'h424D, 54, INFO_HDR_SIZE, 2, 2, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, 32'd12, 2, 2, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 2, 2, 16'd32, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 2, 2, BITS_PER_PIX, 32'd1, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 0, 2, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, MAX_WIDTH + 1, 2, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 32'hFFFF_FFFF, 2, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 2, 0, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 2, MAX_HEIGHT + 1, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 2, -(MAX_HEIGHT + 1), BITS_PER_PIX, '0, 34,
             1'b0);
    send_bmp(BMP_SIGNATURE, 53, INFO_HDR_SIZE, 2, 2, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 0, INFO_HDR_SIZE, 2, 2, BITS_PER_PIX, '0, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 0, 2, BITS_PER_PIX, 32'd3, 34, 1'b0);
    send_bmp(BMP_SIGNATURE, 10, INFO_HDR_SIZE, 0, 2, BITS_PER_PIX, '0, 34, 1'b0);

    // largest sizes: maximum width and height accepted, rows cut short
    in_burst = 1'b1;
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, MAX_WIDTH, 1, BITS_PER_PIX, '0, 61, 1'b1);
    in_burst = 1'b0;
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 1, MAX_HEIGHT, BITS_PER_PIX, '0, 61, 1'b1);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 2, -MAX_HEIGHT, BITS_PER_PIX, '0, 64, 1'b1);

    // early end in header and skip, abandon by a new file, end together with first byte
    send_valid_bmp(2, 2, 54, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 2, 2, BITS_PER_PIX, '0, 20, 1'b1);
    send_bmp(BMP_SIGNATURE, 80, INFO_HDR_SIZE, 2, 2, BITS_PER_PIX, '0, 60, 1'b1);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 3, 2, BITS_PER_PIX, '0, 59, 1'b0);
    send_bmp(BMP_SIGNATURE, 54, INFO_HDR_SIZE, 3, 2, BITS_PER_PIX, '0, 58, 1'b0);
    send_byte(8'($urandom), 1'b1, 1'b1);
    repeat (2) send_byte(8'($urandom), 1'b0, 1'b0);

    rand_start = sb.live_items;
    while (sb.live_items - rand_start < RANDOM_ITEMS) begin
      in_burst = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 1)) h = -h;
      ofs = ($urandom_range(0, 2) == 0) ? 54 + $urandom_range(1, 6) : 54;
      full = image_len(w, h, ofs);
      case ($urandom_range(0, 3))
        0, 1: send_valid_bmp(w, h, ofs, $urandom_range(0, 3) == 0);
        2: begin
          if ($urandom_range(0, 1)) begin
            send_bmp(BMP_SIGNATURE, ofs, INFO_HDR_SIZE, w, h, BITS_PER_PIX, '0,
                     $urandom_range(1, full - 1), $urandom_range(0, 2) != 0);
          end else begin
            sig = BMP_SIGNATURE;
            hsz = INFO_HDR_SIZE;
            bpp = BITS_PER_PIX;
            comp = '0;
            wv = w;
            hv = h;
            ov = ofs;
            case ($urandom_range(0, 6))
              0: sig = 16'($urandom);
              1: hsz = $urandom;
              2: bpp = 16'($urandom);
              3: comp = $urandom;
              4: begin
                case ($urandom_range(0, 2))
                  0: wv = '0;
                  1: wv = MAX_WIDTH + 1 + $urandom_range(0, 1000);
                  default: wv = $urandom | 32'h8000_0000;
                endcase
              end
              5: begin
                case ($urandom_range(0, 2))
                  0: hv = '0;
                  1: hv = MAX_HEIGHT + 1 + $urandom_range(0, 1000);
                  default: hv = -(MAX_HEIGHT + 1 + $urandom_range(0, 1000));
                endcase
              end
              default: ov = $urandom_range(0, 53);
            endcase
            send_bmp(sig, ov, hsz, wv, hv, bpp, comp, 54 + $urandom_range(0, 3), 1'b0);
          end
        end
        default: begin
          repeat ($urandom_range(1, 8))
            send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end
      endcase
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d bytes sent, %0d files started, %0d bytes parsed", bytes_sent, sb.files,
             sb.live_items);
    $display("Checked %0d pixels, %0d finished images, %0d error items, %0d mismatches",
             sb.pixels, sb.dones, sb.errors, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
